>>> sv/ipd_pkg.sv
`default_nettype none

package ipd_pkg;

  localparam int FRAC_BITS  = 8;
  localparam int GAIN_W     = 16;
  localparam int POS_W      = 16;
  localparam int ERR_W      = POS_W + 1;
  localparam int D1_W       = ERR_W + 1;
  localparam int D2_W       = ERR_W + 2;
  localparam int PKP_W      = GAIN_W + D1_W;
  localparam int PKI_W      = GAIN_W + ERR_W;
  localparam int PKD_W      = GAIN_W + D2_W;
  localparam int SUM_W      = PKD_W + 3;
  localparam int LIM_W      = 7;
  localparam int ACC_W      = FRAC_BITS + LIM_W + 1;
  localparam int DRV_W      = 8;
  localparam int DB_W       = 15;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [LIM_W-1:0] CEILING_RST = '1;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_ENABLE = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KP      = 3'd0,
    REG_KI      = 3'd1,
    REG_KD      = 3'd2,
    REG_TARGET  = 3'd3,
    REG_DB      = 3'd4,
    REG_CEILING = 3'd5,
    REG_FLOOR   = 3'd6,
    REG_INVERT  = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0] kp;
    logic signed [GAIN_W-1:0] ki;
    logic signed [GAIN_W-1:0] kd;
    logic signed [POS_W-1:0]  target;
    logic [DB_W-1:0]          dead_band;
    logic [LIM_W-1:0]         ceiling;
    logic [LIM_W-1:0]         floor;
    logic                     invert;
  } cfg_t;

  typedef struct packed {
    op_t                     op;
    logic signed [ERR_W-1:0] err;
    logic                    db_hit;
  } s1_t;

  typedef struct packed {
    op_t                     op;
    logic signed [ERR_W-1:0] err;
    logic                    db_hit;
    logic signed [PKP_W-1:0] pkp;
    logic signed [PKI_W-1:0] pki;
    logic signed [PKD_W-1:0] pkd;
  } s2_t;

  typedef struct packed {
    logic signed [ERR_W-1:0] last;
    logic signed [ERR_W-1:0] prev;
  } hist_t;

endpackage

`default_nettype wire

>>> sv/ipd_cfg.sv
`default_nettype none

module ipd_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [ipd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ipd_pkg::CFG_DATA_W-1:0] cfg_data,
  output ipd_pkg::cfg_t                       cfg
);
  import ipd_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_KP:      cfg_nxt.kp        = $signed(cfg_data[GAIN_W-1:0]);
        REG_KI:      cfg_nxt.ki        = $signed(cfg_data[GAIN_W-1:0]);
        REG_KD:      cfg_nxt.kd        = $signed(cfg_data[GAIN_W-1:0]);
        REG_TARGET:  cfg_nxt.target    = $signed(cfg_data[POS_W-1:0]);
        REG_DB:      cfg_nxt.dead_band = cfg_data[DB_W-1:0];
        REG_CEILING: cfg_nxt.ceiling   = cfg_data[LIM_W-1:0];
        REG_FLOOR:   cfg_nxt.floor     = cfg_data[LIM_W-1:0];
        REG_INVERT:  cfg_nxt.invert    = cfg_data[0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kp        <= '0;
      cfg_r.ki        <= '0;
      cfg_r.kd        <= '0;
      cfg_r.target    <= '0;
      cfg_r.dead_band <= '0;
      cfg_r.ceiling   <= CEILING_RST;
      cfg_r.floor     <= '0;
      cfg_r.invert    <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

>>> sv/ipd_front.sv
`default_nettype none

module ipd_front (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  ipd_pkg::cfg_t                         cfg,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic                             in_op,
  input  wire logic signed [ipd_pkg::POS_W-1:0] in_feedback,
  output logic                                  s1_valid,
  input  wire logic                             s1_ready,
  output ipd_pkg::s1_t                          s1
);
  import ipd_pkg::*;

  logic                    s1_v_r;
  s1_t                     s1_r;
  s1_t                     s1_nxt;
  logic signed [ERR_W-1:0] err;
  logic [ERR_W-1:0]        mag;

  // error and deadband test are state free, so they are done on the way in
  always_comb begin
    err = ERR_W'(cfg.target) - ERR_W'(in_feedback);
    mag = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
    s1_nxt.op     = op_t'(in_op);
    s1_nxt.err    = err;
    s1_nxt.db_hit = (mag <= ERR_W'(cfg.dead_band));
  end

  assign in_ready = !s1_v_r || s1_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ready) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_r <= s1_nxt;
    end
  end

  assign s1_valid = s1_v_r;
  assign s1       = s1_r;

endmodule

`default_nettype wire

>>> sv/ipd_mul.sv
`default_nettype none

module ipd_mul (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  ipd_pkg::cfg_t cfg,
  input  ipd_pkg::hist_t hist,
  input  wire logic     s1_valid,
  output logic          s1_ready,
  input  ipd_pkg::s1_t  s1,
  output logic          s2_valid,
  input  wire logic     s2_ready,
  output ipd_pkg::s2_t  s2
);
  import ipd_pkg::*;

  logic                    s2_v_r;
  s2_t                     s2_r;
  s2_t                     s2_nxt;
  logic signed [D1_W-1:0]  d1;
  logic signed [D2_W-1:0]  d2;

  always_comb begin
    d1 = D1_W'(s1.err) - D1_W'(hist.last);
    d2 = D2_W'(s1.err) - D2_W'(hist.last) - D2_W'(hist.last) + D2_W'(hist.prev);
    s2_nxt.op     = s1.op;
    s2_nxt.err    = s1.err;
    s2_nxt.db_hit = s1.db_hit;
    s2_nxt.pkp    = cfg.kp * d1;
    s2_nxt.pki    = cfg.ki * s1.err;
    s2_nxt.pkd    = cfg.kd * d2;
  end

  assign s1_ready = !s2_v_r || s2_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s1_ready) begin
      s2_v_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_ready) begin
      s2_r <= s2_nxt;
    end
  end

  assign s2_valid = s2_v_r;
  assign s2       = s2_r;

endmodule

`default_nettype wire

>>> sv/ipd_core.sv
`default_nettype none

module ipd_core (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  ipd_pkg::cfg_t                         cfg,
  input  wire logic                             s2_valid,
  output logic                                  s2_ready,
  input  ipd_pkg::s2_t                          s2,
  output ipd_pkg::hist_t                        hist,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic signed [ipd_pkg::DRV_W-1:0]      out_motor_drive,
  output logic signed [ipd_pkg::DRV_W-1:0]      out_next_drive,
  output logic                                  out_aimed,
  output logic                                  out_active
);
  import ipd_pkg::*;

  logic                    armed_r, armed_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic signed [ERR_W-1:0] last_r, last_nxt;
  logic signed [ERR_W-1:0] prev_r, prev_nxt;
  logic signed [DRV_W-1:0] held_r, held_nxt;
  logic                    out_v_r;
  logic signed [DRV_W-1:0] motor_r, motor_nxt;
  logic signed [DRV_W-1:0] next_r, next_nxt;
  logic                    aimed_r, aimed_nxt;
  logic                    active_r, active_nxt;

  logic                    commit;
  logic                    shift;
  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] ceil_v;
  logic signed [SUM_W-1:0] floor_v;
  logic signed [SUM_W-1:0] lim;
  logic signed [ACC_W-1:0] acc_lim;
  logic [ACC_W-1:0]        acc_mag;
  logic [DRV_W-1:0]        int_mag;
  logic signed [DRV_W-1:0] drive_new;
  logic signed [DRV_W-1:0] applied;

  assign s2_ready = !out_v_r || out_ready;
  assign commit   = s2_valid && s2_ready;
  assign shift    = s2_valid && (s2.op == OP_SAMPLE) && armed_r && !s2.db_hit;

  // history bypass for the transaction entering the multiply stage
  always_comb begin
    if (shift) begin
      hist.last = s2.err;
      hist.prev = last_r;
    end else begin
      hist.last = last_r;
      hist.prev = prev_r;
    end
  end

  always_comb begin
    sum = SUM_W'(acc_r) + SUM_W'(s2.pkp) + SUM_W'(s2.pki) + SUM_W'(s2.pkd);
    ceil_v  = $signed(SUM_W'({cfg.ceiling, {FRAC_BITS{1'b0}}}));
    floor_v = $signed(SUM_W'({cfg.floor, {FRAC_BITS{1'b0}}}));
    priority if (sum > ceil_v) begin
      lim = ceil_v;
    end else if (sum < -ceil_v) begin
      lim = -ceil_v;
    end else if (!sum[SUM_W-1] && (sum < floor_v)) begin
      lim = floor_v;
    end else if (sum[SUM_W-1] && (sum > -floor_v)) begin
      lim = -floor_v;
    end else begin
      lim = sum;
    end
    acc_lim   = ACC_W'(lim);
    acc_mag   = acc_lim[ACC_W-1] ? ACC_W'(-acc_lim) : ACC_W'(acc_lim);
    int_mag   = acc_mag[ACC_W-1:FRAC_BITS];
    drive_new = acc_lim[ACC_W-1] ? DRV_W'(-$signed(int_mag)) : $signed(int_mag);
    applied   = cfg.invert ? DRV_W'(-held_r) : held_r;
  end

  always_comb begin
    armed_nxt  = armed_r;
    acc_nxt    = acc_r;
    last_nxt   = last_r;
    prev_nxt   = prev_r;
    held_nxt   = held_r;
    motor_nxt  = '0;
    next_nxt   = '0;
    aimed_nxt  = 1'b0;
    active_nxt = 1'b0;
    if (s2.op == OP_ENABLE) begin
      armed_nxt = 1'b1;
      held_nxt  = '0;
    end else if (armed_r) begin
      motor_nxt  = applied;
      active_nxt = 1'b1;
      if (s2.db_hit) begin
        armed_nxt = 1'b0;
        held_nxt  = '0;
        aimed_nxt = 1'b1;
      end else begin
        acc_nxt  = acc_lim;
        prev_nxt = last_r;
        last_nxt = s2.err;
        held_nxt = drive_new;
        next_nxt = drive_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r <= 1'b0;
      acc_r   <= '0;
      last_r  <= '0;
      prev_r  <= '0;
      held_r  <= '0;
      out_v_r <= 1'b0;
    end else begin
      if (s2_ready) begin
        out_v_r <= s2_valid;
      end
      if (commit) begin
        armed_r <= armed_nxt;
        acc_r   <= acc_nxt;
        last_r  <= last_nxt;
        prev_r  <= prev_nxt;
        held_r  <= held_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      motor_r  <= motor_nxt;
      next_r   <= next_nxt;
      aimed_r  <= aimed_nxt;
      active_r <= active_nxt;
    end
  end

  assign out_valid       = out_v_r;
  assign out_motor_drive = motor_r;
  assign out_next_drive  = next_r;
  assign out_aimed       = aimed_r;
  assign out_active      = active_r;

endmodule

`default_nettype wire

>>> sv/incremental_pid_deadband_unit.sv
// Incremental PID position loop with deadband and drive limits.
// Input channel (in_valid/in_ready): in_op selects a sample transaction (0)
// carrying in_feedback, or an enable transaction (1) that arms the loop and
// zeroes the held drive.
// Result channel (out_valid/out_ready): one result per input transaction,
// with the drive applied this tick, the new held drive, aimed and active.
// Configuration port: cfg_we writes cfg_data to the register at cfg_index
// at the clock edge; write only while no transaction is in flight.
// Pipeline: input register, gain multiply stage, accumulate/limit stage into
// the output register; out_valid rises once a transaction has passed all
// three and stays high until out_ready takes the result.
// Throughput: 1 transaction per cycle while out_ready is high; the
// accumulator update and limiting are combinational ahead of the output
// register and error history is bypassed into the multiply stage.
// Reset (rst_n low at a clock edge): loop disarmed, accumulator, error
// history and held drive cleared, gains zero, ceiling 127, invert set.
// When out_ready is low the pipeline holds; in_ready drops once all three
// stages are full.
`default_nettype none

module incremental_pid_deadband_unit (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic                             in_op,
  input  wire logic signed [ipd_pkg::POS_W-1:0] in_feedback,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic signed [ipd_pkg::DRV_W-1:0]      out_motor_drive,
  output logic signed [ipd_pkg::DRV_W-1:0]      out_next_drive,
  output logic                                  out_aimed,
  output logic                                  out_active,
  input  wire logic                             cfg_we,
  input  wire logic [ipd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [ipd_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import ipd_pkg::*;

  cfg_t  cfg;
  hist_t hist;
  s1_t   s1;
  s2_t   s2;
  logic  s1_valid, s1_ready;
  logic  s2_valid, s2_ready;

  ipd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ipd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_op       (in_op),
    .in_feedback (in_feedback),
    .s1_valid    (s1_valid),
    .s1_ready    (s1_ready),
    .s1          (s1)
  );

  ipd_mul u_mul (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .hist     (hist),
    .s1_valid (s1_valid),
    .s1_ready (s1_ready),
    .s1       (s1),
    .s2_valid (s2_valid),
    .s2_ready (s2_ready),
    .s2       (s2)
  );

  ipd_core u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .s2_valid        (s2_valid),
    .s2_ready        (s2_ready),
    .s2              (s2),
    .hist            (hist),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_motor_drive (out_motor_drive),
    .out_next_drive  (out_next_drive),
    .out_aimed       (out_aimed),
    .out_active      (out_active)
  );

endmodule

`default_nettype wire
